>>> hdl/lpcld_pkg.sv
// Shared widths and types for the LPC Levinson-Durbin unit.
package lpcld_pkg;

  localparam int SMP_W  = 16;  // input sample
  localparam int LAG_W  = 48;  // autocorrelation lag sum
  localparam int RN_W   = 25;  // normalized lag, +-(2^24-1)
  localparam int COEF_W = 32;  // Q4.27 coefficient
  localparam int PROD_W = 64;  // multiplier product / recursion accumulator
  localparam int ERR_W  = 24;  // prediction error, below 2^24

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic        [ERR_W-1:0]  err_t;

endpackage

>>> hdl/lpc_levinson_durbin_unit.sv
// LPC analysis top level: per-sample autocorrelation, then Levinson-Durbin recursion.
// Busy while it processes a sample: one shared multiply per lag, so a new sample is
// taken only after the last one is through. On frame end add normalization and,
// per order step i, the recursion sum, a divide and a pairwise coefficient update,
// then one result per cycle.
// Results are single-cycle strobes; the receiver cannot stall. Sync reset clears lags,
// delay line and state, and loads order 10 and silence threshold 1.
module lpc_levinson_durbin_unit #(
  parameter int MAX_ORDER = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [lpcld_pkg::SMP_W-1:0] sample,
  input  logic                               frame_end,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic        [lpcld_pkg::LAG_W-1:0] cfg_data,
  output logic                               coef_valid,
  output logic        [4:0]                  coef_index,
  output logic signed [lpcld_pkg::COEF_W-1:0] coef_value,
  output logic                               silent,
  output logic                               run_last
);
  import lpcld_pkg::*;

  localparam int CW = $clog2(MAX_ORDER + 2);
  localparam logic [CW-1:0] LAST_LAG = CW'(MAX_ORDER);
  localparam logic [CW-1:0] ACC_END  = CW'(MAX_ORDER + 1);
  localparam logic [CW-1:0] ONE_C    = CW'(1);

  localparam logic signed [COEF_W-1:0] ONE_Q27 = 32'sd134217728;
  localparam logic signed [LAG_W-1:0]  NORM_HI = 48'sd16777215;
  localparam logic signed [LAG_W-1:0]  NORM_LO = -48'sd16777215;

  localparam logic [0:0] REG_ORDER  = 1'b0;
  localparam logic [0:0] REG_THRESH = 1'b1;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_ACC    = 5'd1;
  localparam logic [4:0] S_SHIFT  = 5'd2;
  localparam logic [4:0] S_DECIDE = 5'd3;
  localparam logic [4:0] S_NORMS  = 5'd4;
  localparam logic [4:0] S_NORM   = 5'd5;
  localparam logic [4:0] S_RINIT  = 5'd6;
  localparam logic [4:0] S_R0     = 5'd7;
  localparam logic [4:0] S_R1     = 5'd8;
  localparam logic [4:0] S_R2     = 5'd9;
  localparam logic [4:0] S_KDEC   = 5'd10;
  localparam logic [4:0] S_DIVW   = 5'd11;
  localparam logic [4:0] S_KST    = 5'd12;
  localparam logic [4:0] S_U0     = 5'd13;
  localparam logic [4:0] S_U1     = 5'd14;
  localparam logic [4:0] S_U2     = 5'd15;
  localparam logic [4:0] S_U3     = 5'd16;
  localparam logic [4:0] S_U4     = 5'd17;
  localparam logic [4:0] S_E0     = 5'd18;
  localparam logic [4:0] S_E1     = 5'd19;
  localparam logic [4:0] S_E2     = 5'd20;
  localparam logic [4:0] S_NEXTI  = 5'd21;
  localparam logic [4:0] S_EMIT   = 5'd22;

  logic [4:0] state;

  // configuration
  logic [4:0]       lpc_order;
  logic [LAG_W-1:0] silence_threshold;

  // frame and recursion state
  logic signed [SMP_W-1:0]  x;
  logic                     fe;
  logic [CW-1:0]            ord;
  logic [CW-1:0]            cnt;
  logic [CW-1:0]            i;
  logic [CW-1:0]            j;
  logic [4:0]               s;
  logic [LAG_W-1:0]         rsh;
  logic signed [SMP_W-1:0]  sample_delay [MAX_ORDER];
  logic signed [LAG_W-1:0]  lag_accum [MAX_ORDER+1];
  logic signed [RN_W-1:0]   rn [MAX_ORDER+1];
  coef_t                    coef_store [MAX_ORDER+1];
  prod_t                    acc;
  coef_t                    kq;
  coef_t                    aj;
  coef_t                    aij;
  err_t                     pred_error;
  logic                     silent_r;

  // shared units
  coef_t mul_a;
  coef_t mul_b;
  prod_t prod;
  logic  div_start;
  logic  div_done;
  coef_t div_q;

  lpcld_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  lpcld_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (pred_error),
    .done     (div_done),
    .quot     (div_q)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign div_start = (state == S_KDEC) && (pred_error != '0);

  // clamped order
  logic [CW-1:0] ord_clamp;
  always_comb begin
    if (lpc_order == 5'd0)                 ord_clamp = ONE_C;
    else if (int'(lpc_order) > MAX_ORDER)  ord_clamp = LAST_LAG;
    else                                   ord_clamp = CW'(lpc_order);
  end

  // read selects
  logic [CW-1:0]           lag_addr;
  logic [CW-1:0]           rn_addr;
  logic [CW-1:0]           coef_addr;
  logic signed [LAG_W-1:0] lag_rd;
  logic signed [RN_W-1:0]  rn_rd;
  coef_t                   coef_rd;
  logic signed [SMP_W-1:0] tap;

  assign lag_addr  = (state == S_ACC) ? CW'(cnt - ONE_C) : cnt;
  assign rn_addr   = (state == S_R0) ? i : CW'(i - j);
  assign coef_addr = (state == S_U1) ? CW'(i - j) : j;

  always_comb begin
    lag_rd  = '0;
    rn_rd   = '0;
    coef_rd = '0;
    tap     = x;
    for (int q = 0; q <= MAX_ORDER; q++) begin
      if (lag_addr == CW'(q))  lag_rd  = lag_accum[q];
      if (rn_addr == CW'(q))   rn_rd   = rn[q];
      if (coef_addr == CW'(q)) coef_rd = coef_store[q];
    end
    for (int q = 0; q < MAX_ORDER; q++) begin
      if (cnt == CW'(q + 1)) tap = sample_delay[q];
    end
  end

  // derived arithmetic
  logic [LAG_W:0]          lag_sum;
  logic signed [LAG_W-1:0] lag_sat;
  logic signed [LAG_W-1:0] lag_shr;
  logic signed [RN_W-1:0]  rn_new;
  prod_t                   prod_sh;
  logic signed [39:0]      upd_j;
  logic signed [39:0]      upd_ij;
  logic                    t_big;
  logic [27:0]             one_minus_t;

  assign lag_sum = {lag_rd[LAG_W-1], lag_rd} + prod[LAG_W:0];
  always_comb begin
    if (lag_sum[LAG_W] != lag_sum[LAG_W-1])
      lag_sat = lag_sum[LAG_W] ? {1'b1, {(LAG_W-1){1'b0}}} : {1'b0, {(LAG_W-1){1'b1}}};
    else
      lag_sat = lag_sum[LAG_W-1:0];
  end

  assign lag_shr = lag_rd >>> s;
  always_comb begin
    if (lag_shr > NORM_HI)      rn_new = RN_W'(NORM_HI);
    else if (lag_shr < NORM_LO) rn_new = RN_W'(NORM_LO);
    else                        rn_new = lag_shr[RN_W-1:0];
  end

  assign prod_sh = prod >>> 27;
  assign upd_j   = {{8{aj[COEF_W-1]}}, aj} - prod_sh[39:0];
  assign upd_ij  = {{8{aij[COEF_W-1]}}, aij} - prod_sh[39:0];

  function automatic coef_t sat32(input logic signed [39:0] v);
    if (v > 40'sh00_7FFF_FFFF)      sat32 = 32'sh7FFF_FFFF;
    else if (v < -40'sh00_8000_0000) sat32 = 32'sh8000_0000;
    else                             sat32 = v[COEF_W-1:0];
  endfunction

  assign t_big       = (prod >= 64'sh0040_0000_0000_0000);
  assign one_minus_t = 28'd134217728 - {1'b0, prod[53:27]};

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_ACC: begin
        mul_a = {{(COEF_W-SMP_W){x[SMP_W-1]}}, x};
        mul_b = {{(COEF_W-SMP_W){tap[SMP_W-1]}}, tap};
      end
      S_R1: begin
        mul_a = coef_rd;
        mul_b = {{(COEF_W-RN_W){rn_rd[RN_W-1]}}, rn_rd};
      end
      S_U2: begin
        mul_a = kq;
        mul_b = aij;
      end
      S_U3: begin
        mul_a = kq;
        mul_b = aj;
      end
      S_E0: begin
        mul_a = kq;
        mul_b = kq;
      end
      S_E1: begin
        mul_a = {{(COEF_W-ERR_W){1'b0}}, pred_error};
        mul_b = {4'd0, one_minus_t};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      lpc_order         <= 5'd10;
      silence_threshold <= 48'd1;
      pred_error        <= '0;
      coef_valid        <= 1'b0;
      for (int q = 0; q < MAX_ORDER; q++) sample_delay[q] <= '0;
      for (int q = 0; q <= MAX_ORDER; q++) lag_accum[q] <= '0;
    end else begin
      coef_valid <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ORDER:  lpc_order <= cfg_data[4:0];
          REG_THRESH: silence_threshold <= cfg_data;
          default:    lpc_order <= lpc_order;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            x     <= sample;
            fe    <= frame_end;
            cnt   <= '0;
            state <= S_ACC;
          end
        end

        // issue lag cnt, accumulate lag cnt-1
        S_ACC: begin
          if (cnt != '0) begin
            for (int q = 0; q <= MAX_ORDER; q++)
              if (lag_addr == CW'(q)) lag_accum[q] <= lag_sat;
          end
          if (cnt == ACC_END) state <= S_SHIFT;
          cnt <= CW'(cnt + ONE_C);
        end

        S_SHIFT: begin
          sample_delay[0] <= x;
          for (int q = 1; q < MAX_ORDER; q++) sample_delay[q] <= sample_delay[q-1];
          ord   <= ord_clamp;
          state <= fe ? S_DECIDE : S_IDLE;
        end

        S_DECIDE: begin
          for (int q = 1; q <= MAX_ORDER; q++) coef_store[q] <= '0;
          coef_store[0] <= ONE_Q27;
          silent_r      <= (lag_accum[0] < $signed({1'b0, silence_threshold}));
          if ($unsigned(lag_accum[0]) < silence_threshold) begin
            pred_error <= '0;
            j          <= ONE_C;
            state      <= S_EMIT;
          end else begin
            rsh   <= lag_accum[0];
            s     <= '0;
            state <= S_NORMS;
          end
        end

        // one-bit-per-cycle shift search
        S_NORMS: begin
          if (rsh >= 48'd16777216) begin
            rsh <= rsh >> 1;
            s   <= s + 5'd1;
          end else begin
            cnt   <= '0;
            state <= S_NORM;
          end
        end

        S_NORM: begin
          for (int q = 0; q <= MAX_ORDER; q++)
            if (cnt == CW'(q)) rn[q] <= rn_new;
          cnt <= CW'(cnt + ONE_C);
          if (cnt == LAST_LAG) state <= S_RINIT;
        end

        S_RINIT: begin
          pred_error <= rn[0][ERR_W-1:0];
          i          <= ONE_C;
          state      <= S_R0;
        end

        S_R0: begin
          acc   <= prod_t'({{(PROD_W-RN_W){rn_rd[RN_W-1]}}, rn_rd}) <<< 27;
          j     <= ONE_C;
          state <= S_R1;
        end

        S_R1: begin
          state <= (j < i) ? S_R2 : S_KDEC;
        end

        S_R2: begin
          acc   <= acc - prod;
          j     <= CW'(j + ONE_C);
          state <= S_R1;
        end

        S_KDEC: begin
          if (pred_error != '0) begin
            state <= S_DIVW;
          end else begin
            kq    <= '0;
            state <= S_KST;
          end
        end

        S_DIVW: begin
          if (div_done) begin
            kq    <= div_q;
            state <= S_KST;
          end
        end

        S_KST: begin
          for (int q = 0; q <= MAX_ORDER; q++)
            if (i == CW'(q)) coef_store[q] <= kq;
          j     <= ONE_C;
          state <= S_U0;
        end

        // pairwise coefficient update
        S_U0: begin
          if (j > (i >> 1)) begin
            state <= S_E0;
          end else begin
            aj    <= coef_rd;
            state <= S_U1;
          end
        end

        S_U1: begin
          aij   <= coef_rd;
          state <= S_U2;
        end

        S_U2: state <= S_U3;

        S_U3: begin
          for (int q = 0; q <= MAX_ORDER; q++)
            if (j == CW'(q)) coef_store[q] <= sat32(upd_j);
          state <= S_U4;
        end

        S_U4: begin
          if (j != CW'(i - j)) begin
            for (int q = 0; q <= MAX_ORDER; q++)
              if (CW'(i - j) == CW'(q)) coef_store[q] <= sat32(upd_ij);
          end
          j     <= CW'(j + ONE_C);
          state <= S_U0;
        end

        // error update
        S_E0: state <= S_E1;

        S_E1: begin
          if (t_big) begin
            pred_error <= '0;
            state      <= S_NEXTI;
          end else begin
            state <= S_E2;
          end
        end

        S_E2: begin
          pred_error <= prod[ERR_W+26:27];
          state      <= S_NEXTI;
        end

        S_NEXTI: begin
          if (i == ord) begin
            j     <= ONE_C;
            state <= S_EMIT;
          end else begin
            i     <= CW'(i + ONE_C);
            state <= S_R0;
          end
        end

        // one result per cycle, then clear the frame
        S_EMIT: begin
          coef_valid <= 1'b1;
          coef_index <= 5'(j);
          coef_value <= coef_rd;
          silent     <= silent_r;
          run_last   <= (j == ord);
          if (j == ord) begin
            for (int q = 0; q < MAX_ORDER; q++) sample_delay[q] <= '0;
            for (int q = 0; q <= MAX_ORDER; q++) lag_accum[q] <= '0;
            state <= S_IDLE;
          end else begin
            j <= CW'(j + ONE_C);
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/lpcld_mul.sv
// Shared signed 32x32 multiplier with registered product.
module lpcld_mul (
  input  logic          clk,
  input  lpcld_pkg::coef_t op_a,
  input  lpcld_pkg::coef_t op_b,
  output lpcld_pkg::prod_t prod
);
  import lpcld_pkg::*;

  // one multiply per cycle, product registered
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

>>> hdl/lpcld_div.sv
// Radix-2 restoring divider: signed 64-bit dividend by positive error, saturated quotient.
module lpcld_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  lpcld_pkg::prod_t dividend,
  input  lpcld_pkg::err_t  divisor,
  output logic             done,
  output lpcld_pkg::coef_t quot
);
  import lpcld_pkg::*;

  localparam logic [6:0] STEPS = 7'd64;

  logic              run;
  logic [6:0]        cnt;
  logic              neg;
  logic [PROD_W-1:0] num;
  logic [PROD_W-1:0] q;
  logic [ERR_W-1:0]  rem;
  logic [ERR_W-1:0]  dvs;
  logic [ERR_W:0]    trial;
  logic              qbit;

  assign trial = {rem, num[PROD_W-1]};
  assign qbit  = (trial >= {1'b0, dvs});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= STEPS;
      end else if (run) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: one quotient bit per cycle on magnitudes
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[PROD_W-1];
      num <= dividend[PROD_W-1] ? PROD_W'(-dividend) : dividend;
      dvs <= divisor;
      rem <= '0;
      q   <= '0;
    end else if (run) begin
      rem <= qbit ? ERR_W'(trial - {1'b0, dvs}) : trial[ERR_W-1:0];
      num <= {num[PROD_W-2:0], 1'b0};
      q   <= {q[PROD_W-2:0], qbit};
    end
  end

  // sign and saturation to 32 bits
  always_comb begin
    if (!neg) begin
      if (q > 64'h0000_0000_7FFF_FFFF) quot = 32'sh7FFF_FFFF;
      else                             quot = coef_t'(q[COEF_W-1:0]);
    end else begin
      if (q > 64'h0000_0000_8000_0000) quot = 32'sh8000_0000;
      else                             quot = coef_t'(-q[COEF_W-1:0]);
    end
  end

endmodule

>>> sim/tb_lpc_levinson_durbin_unit.sv
// Self-checking testbench for lpc_levinson_durbin_unit: frame stimulus, coefficient prediction.
module tb_lpc_levinson_durbin_unit;
  import lpcld_pkg::*;

  localparam int     NMAX    = 16;
  localparam int     IDX_ORDER  = 0;
  localparam int     IDX_THRESH = 1;
  localparam longint ONE_Q27 = 64'sd1 << 27;
  localparam longint LAG_HI  = (64'sd1 << 47) - 1;
  localparam longint LAG_LO  = -(64'sd1 << 47);
  localparam longint NORM_LIM = 64'sd1 << 24;
  localparam longint THRESH_MAX = (64'sd1 << 48) - 1;
  localparam int     WDOG_LIMIT = 20000;

  typedef struct {
    logic signed [SMP_W-1:0] smp;
    logic                    fend;
  } sample_req_t;

  typedef struct {
    logic [4:0]  idx;
    coef_t       value;
    logic        sil;
    logic        last;
  } coef_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [SMP_W-1:0] sample = '0;
  logic frame_end = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [LAG_W-1:0] cfg_data = '0;
  logic coef_valid;
  logic [4:0] coef_index;
  coef_t coef_value;
  logic silent;
  logic run_last;

  lpc_levinson_durbin_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .frame_end(frame_end), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .coef_valid(coef_valid),
    .coef_index(coef_index), .coef_value(coef_value), .silent(silent),
    .run_last(run_last)
  );

  always #10 clk = ~clk;

  sample_req_t sample_q[$];
  coef_res_t   coef_expect_q[$];
  int errors = 0;
  bit quiet = 0;
  bit took = 0;
  int gap = 0;
  int idle_cycles = 0;

  // predictor state
  int     order_reg = 10;
  longint thresh_reg = 1;
  longint delay_line[NMAX];
  longint lag_sum[NMAX+1];
  longint coef_q27[NMAX+1];

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sat_lag(longint v);
    if (v > LAG_HI) return LAG_HI;
    if (v < LAG_LO) return LAG_LO;
    return v;
  endfunction

  // Levinson-Durbin recursion over normalized lags
  function automatic void solve_lpc(int order);
    longint rn[NMAX+1];
    longint err, acc, k, t, aj, aij, v;
    int s;
    s = 0;
    while ((lag_sum[0] >>> s) >= NORM_LIM) s++;
    for (int i = 0; i <= NMAX; i++) begin
      v = lag_sum[i] >>> s;
      if (v > NORM_LIM - 1) v = NORM_LIM - 1;
      if (v < -(NORM_LIM - 1)) v = -(NORM_LIM - 1);
      rn[i] = v;
    end
    coef_q27[0] = ONE_Q27;
    for (int i = 1; i <= NMAX; i++) coef_q27[i] = 0;
    err = (rn[0] > 0) ? rn[0] : 0;
    for (int i = 1; i <= order; i++) begin
      acc = rn[i] * ONE_Q27;
      k = 0;
      for (int j = 1; j < i; j++) acc -= coef_q27[j] * rn[i-j];
      if (err > 0) k = sat32(acc / err);
      coef_q27[i] = k;
      for (int j = 1; j <= i / 2; j++) begin
        aj = coef_q27[j];
        aij = coef_q27[i-j];
        coef_q27[j] = sat32(aj - ((k * aij) >>> 27));
        if (j != i - j) coef_q27[i-j] = sat32(aij - ((k * aj) >>> 27));
      end
      t = (k * k) >>> 27;
      if (t >= ONE_Q27) err = 0;
      else err = (err * (ONE_Q27 - t)) >>> 27;
    end
  endfunction

  // accumulate one sample; on frame end queue the expected coefficients
  function automatic void predict_sample(sample_req_t r);
    longint x;
    int order;
    bit sil;
    coef_res_t c;
    x = longint'(r.smp);
    lag_sum[0] = sat_lag(lag_sum[0] + x * x);
    for (int k = 1; k <= NMAX; k++) lag_sum[k] = sat_lag(lag_sum[k] + x * delay_line[k-1]);
    for (int k = NMAX - 1; k > 0; k--) delay_line[k] = delay_line[k-1];
    delay_line[0] = x;
    if (!r.fend) return;
    order = order_reg;
    if (order < 1) order = 1;
    if (order > NMAX) order = NMAX;
    sil = lag_sum[0] < thresh_reg;
    if (sil) begin
      for (int j = 0; j <= NMAX; j++) coef_q27[j] = 0;
    end else begin
      solve_lpc(order);
    end
    for (int j = 1; j <= order; j++) begin
      c.idx = j[4:0];
      c.value = coef_t'(coef_q27[j]);
      c.sil = sil;
      c.last = (j == order);
      coef_expect_q.push_back(c);
    end
    for (int k = 0; k < NMAX; k++) delay_line[k] = 0;
    for (int k = 0; k <= NMAX; k++) lag_sum[k] = 0;
  endfunction

  // request acceptance and result check
  always @(posedge clk) begin
    coef_res_t e;
    took = 0;
    if (!rst) begin
      if (start && !busy) begin
        sample_req_t r;
        r.smp = sample;
        r.fend = frame_end;
        predict_sample(r);
        took = 1;
      end
      if (coef_valid) begin
        if (coef_expect_q.size() == 0) begin
          $display("%0t: unexpected result idx=%0d value=%0d", $time, coef_index, coef_value);
          errors++;
        end else begin
          e = coef_expect_q.pop_front();
          if (coef_index !== e.idx) begin
            $display("%0t: coef_index exp %0d got %0d", $time, e.idx, coef_index);
            errors++;
          end
          if (coef_value !== e.value) begin
            $display("%0t: coef_value[%0d] exp %0d got %0d", $time, e.idx, e.value,
                     coef_value);
            errors++;
          end
          if (silent !== e.sil) begin
            $display("%0t: silent[%0d] exp %0b got %0b", $time, e.idx, e.sil, silent);
            errors++;
          end
          if (run_last !== e.last) begin
            $display("%0t: run_last[%0d] exp %0b got %0b", $time, e.idx, e.last, run_last);
            errors++;
          end
        end
      end
    end
  end

  // driver: presents queued requests, random idle bursts
  always @(negedge clk) begin
    sample_req_t r;
    if (!rst) begin
      if (start && !took) begin
        // hold current request
      end else if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (sample_q.size() > 0) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
          gap = $urandom_range(1, 15) - 1;
          start <= 1'b0;
        end else begin
          r = sample_q.pop_front();
          sample <= r.smp;
          frame_end <= r.fend;
          start <= 1'b1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (took || coef_valid || (cfg_valid && cfg_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(bit idx, longint value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[LAG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == IDX_ORDER) order_reg = int'(value[4:0]);
    else thresh_reg = value & THRESH_MAX;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sample_q.size() > 0 || start || coef_expect_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic push_sample(int v, bit fend);
    sample_req_t r;
    r.smp = v[SMP_W-1:0];
    r.fend = fend;
    sample_q.push_back(r);
  endtask

  // frame styles: full-range noise, correlated walk, low level
  task automatic add_frame(int len, int style);
    int x;
    x = $urandom_range(0, 65535) - 32768;
    for (int n = 0; n < len; n++) begin
      case (style)
        0: x = $urandom_range(0, 65535) - 32768;
        1: begin
          x = x + $urandom_range(0, 4000) - 2000;
          if (x > 32767) x = 32767;
          if (x < -32768) x = -32768;
        end
        default: x = $urandom_range(0, 16) - 8;
      endcase
      push_sample(x, n == len - 1);
    end
  endtask

  initial begin
    int nitems;
    for (int k = 0; k < NMAX; k++) delay_line[k] = 0;
    for (int k = 0; k <= NMAX; k++) begin
      lag_sum[k] = 0;
      coef_q27[k] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes at reset defaults, a silent all-zero frame, then a full-scale one
    push_sample(32767, 0);
    push_sample(-32768, 0);
    push_sample(0, 0);
    push_sample(-1, 0);
    push_sample(32767, 1);
    push_sample(0, 1);
    push_sample(-32768, 1);
    wait_idle();

    // order 0 counts as 1; zero energy with threshold 0 is not silent
    write_reg(IDX_ORDER, 0);
    write_reg(IDX_THRESH, 0);
    push_sample(0, 0);
    push_sample(0, 1);
    add_frame(5, 1);
    wait_idle();

    // order above max clamps; huge threshold makes everything silent
    write_reg(IDX_ORDER, 31);
    write_reg(IDX_THRESH, THRESH_MAX);
    add_frame(6, 0);
    wait_idle();

    // max order, alternating full-scale frame
    write_reg(IDX_ORDER, 16);
    write_reg(IDX_THRESH, 1);
    for (int n = 0; n < 40; n++) push_sample((n % 2) ? -32768 : 32767, n == 39);
    add_frame(20, 1);
    wait_idle();

    // random phases
    nitems = 0;
    while (nitems < 100) begin
      case ($urandom_range(0, 5))
        0: write_reg(IDX_ORDER, $urandom_range(0, 31));
        default: write_reg(IDX_ORDER, $urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(IDX_THRESH, {$urandom(), $urandom()} & THRESH_MAX);
        1: write_reg(IDX_THRESH, 0);
        default: write_reg(IDX_THRESH, $urandom_range(0, 2000));
      endcase
      if (nitems > 70) quiet = 1;
      for (int f = 0; f < 3; f++) begin
        int len;
        len = $urandom_range(1, 40);
        add_frame(len, $urandom_range(0, 3) == 0 ? 0 : ($urandom_range(0, 4) == 0 ? 2 : 1));
        nitems += len;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
